// ===== rtl/tcpq_pkg.sv =====
package tcpq_pkg;

  localparam int OP_W       = 2;
  localparam int PKT_TAG_W  = 16;
  localparam int PKT_TICK_W = 16;
  localparam int COUNT_W    = 7;
  localparam int LIMIT_W    = 7;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [OP_W-1:0] OP_DATA     = 2'd0;
  localparam logic [OP_W-1:0] OP_FEEDBACK = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd2;

  localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RESET = 7'd64;

  // register index taken from paddr[2]
  localparam logic REG_QUEUE_LIMIT = 1'b0;

  typedef struct packed {
    logic [OP_W-1:0]       operation;
    logic [PKT_TAG_W-1:0]  packet_tag;
    logic [PKT_TICK_W-1:0] service_ticks;
  } in_item_t;

  typedef struct packed {
    logic                 sent_valid;
    logic [PKT_TAG_W-1:0] sent_tag;
    logic                 sent_is_feedback;
    logic                 dropped;
    logic [COUNT_W-1:0]   data_count;
    logic [COUNT_W-1:0]   feedback_count;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic pop;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== rtl/tcpq_in_if.sv =====
interface tcpq_in_if;
  import tcpq_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/tcpq_out_if.sv =====
interface tcpq_out_if;
  import tcpq_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/tcpq_fifo.sv =====
module tcpq_fifo #(
  parameter int DEPTH = 64,
  parameter int W     = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [tcpq_pkg::LIMIT_W-1:0]       limit,
  input  logic                               push,
  input  logic [W-1:0]                       wdata,
  output logic                               push_ok,
  input  logic                               pop,
  output logic [W-1:0]                       rdata,
  output logic [$clog2(DEPTH+1)-1:0]         fill
);
  import tcpq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  logic [W-1:0]  mem [DEPTH];
  logic [W-1:0]  rdata_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r;
  logic [CW:0]   wsum;
  logic [AW-1:0] waddr;
  logic [LIMIT_W-1:0] lim_eff;
  logic          full;

  // a zero limit behaves as one
  assign lim_eff = (limit == '0) ? LIMIT_W'(1) : limit;
  assign full    = (fill_r >= CW'(DEPTH)) || (LW'(fill_r) >= LW'(lim_eff));
  assign push_ok = !full;

  assign wsum  = (CW+1)'(head_r) + (CW+1)'(fill_r);
  assign waddr = (wsum >= (CW+1)'(DEPTH)) ? AW'(wsum - (CW+1)'(DEPTH)) : AW'(wsum);

  assign head_nxt = (head_r == AW'(DEPTH-1)) ? '0 : head_r + AW'(1);

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[waddr] <= wdata;
    end
    if (pop) begin
      rdata_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else if (push && !full) begin
      fill_r <= fill_r + CW'(1);
    end else if (pop) begin
      head_r <= head_nxt;
      fill_r <= fill_r - CW'(1);
    end
  end

  assign rdata = rdata_r;
  assign fill  = fill_r;

endmodule

// ===== rtl/tcpq_datapath.sv =====
module tcpq_datapath #(
  parameter int FIFO_DEPTH = 64,
  parameter int TAG_BITS   = 16,
  parameter int TICK_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcpq_pkg::ctrl_cmd_t           cmd,
  output tcpq_pkg::ctrl_sts_t           sts,
  input  tcpq_pkg::in_item_t            in_item,
  input  logic [tcpq_pkg::LIMIT_W-1:0]  queue_limit,
  input  logic                          out_ready,
  output logic                          out_valid,
  output tcpq_pkg::out_item_t           out_item
);
  import tcpq_pkg::*;

  localparam int CW = $clog2(FIFO_DEPTH+1);
  localparam int EW = TAG_BITS + TICK_BITS;
  localparam logic [31:0] TICK_MAX = 32'((64'd1 << TICK_BITS) - 64'd1);

  logic [OP_W-1:0]      op_r;
  logic [TAG_BITS-1:0]  tag_r;
  logic [TICK_BITS-1:0] dur_r;
  logic                 drop_r;
  logic                 pop_want_r;
  logic                 busy_r;
  logic [TICK_BITS-1:0] ticks_r;
  logic                 sent_r;
  logic                 sent_fb_r;
  logic                 out_valid_r;
  out_item_t            out_item_r;

  logic [31:0]          dur_in;
  logic [31:0]          dur_sat;
  logic [TICK_BITS-1:0] ticks_dec;
  logic                 is_arrival;

  logic          d_push, f_push, d_ok, f_ok, d_pop, f_pop, push_ok;
  logic [EW-1:0] d_rd, f_rd, rd_sel;
  logic [CW-1:0] d_fill, f_fill;

  // zero duration counts as one tick, long ones saturate
  assign dur_in  = (in_item.service_ticks == '0) ? 32'd1 : 32'(in_item.service_ticks);
  assign dur_sat = (dur_in > TICK_MAX) ? TICK_MAX : dur_in;

  assign ticks_dec  = (ticks_r != '0) ? ticks_r - TICK_BITS'(1) : ticks_r;
  assign is_arrival = (op_r == OP_DATA) || (op_r == OP_FEEDBACK);

  assign d_push  = cmd.exec && (op_r == OP_DATA);
  assign f_push  = cmd.exec && (op_r == OP_FEEDBACK);
  assign push_ok = (op_r == OP_DATA) ? d_ok : f_ok;

  // data class has strict priority
  assign d_pop = cmd.pop && pop_want_r && (d_fill != '0);
  assign f_pop = cmd.pop && pop_want_r && (d_fill == '0) && (f_fill != '0);

  tcpq_fifo #(.DEPTH(FIFO_DEPTH), .W(EW)) u_data_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .limit   (queue_limit),
    .push    (d_push),
    .wdata   ({tag_r, dur_r}),
    .push_ok (d_ok),
    .pop     (d_pop),
    .rdata   (d_rd),
    .fill    (d_fill)
  );

  tcpq_fifo #(.DEPTH(FIFO_DEPTH), .W(EW)) u_fb_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .limit   (queue_limit),
    .push    (f_push),
    .wdata   ({tag_r, dur_r}),
    .push_ok (f_ok),
    .pop     (f_pop),
    .rdata   (f_rd),
    .fill    (f_fill)
  );

  assign rd_sel = sent_fb_r ? f_rd : d_rd;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_item.operation;
      tag_r <= TAG_BITS'(in_item.packet_tag);
      dur_r <= dur_sat[TICK_BITS-1:0];
    end
    if (cmd.exec) begin
      drop_r <= is_arrival && !push_ok;
    end
    if (cmd.pop) begin
      sent_fb_r <= (d_fill == '0);
    end
    if (cmd.load_out) begin
      out_item_r.sent_valid       <= sent_r;
      out_item_r.sent_tag         <= sent_r ? PKT_TAG_W'(rd_sel[EW-1:TICK_BITS]) : '0;
      out_item_r.sent_is_feedback <= sent_r && sent_fb_r;
      out_item_r.dropped          <= drop_r;
      out_item_r.data_count       <= COUNT_W'(d_fill);
      out_item_r.feedback_count   <= COUNT_W'(f_fill);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_want_r  <= 1'b0;
      busy_r      <= 1'b0;
      ticks_r     <= '0;
      sent_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        if (is_arrival) begin
          pop_want_r <= !busy_r;
        end else if (op_r == OP_TICK && busy_r) begin
          ticks_r    <= ticks_dec;
          pop_want_r <= (ticks_dec == '0);
        end else begin
          pop_want_r <= 1'b0;
        end
      end
      if (cmd.pop) begin
        sent_r <= pop_want_r && ((d_fill != '0) || (f_fill != '0));
        if (pop_want_r && d_fill == '0 && f_fill == '0) begin
          busy_r  <= 1'b0;
          ticks_r <= '0;
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        if (sent_r) begin
          busy_r  <= 1'b1;
          ticks_r <= rd_sel[TICK_BITS-1:0];
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;

endmodule

// ===== rtl/tcpq_ctrl.sv =====
module tcpq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcpq_pkg::ctrl_sts_t sts,
  output tcpq_pkg::ctrl_cmd_t cmd
);
  import tcpq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_POP;
      S_POP:   state_nxt = S_OUT;
      S_OUT:   if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready     = in_ready_r;
  assign cmd.load_in  = in_valid && in_ready_r;
  assign cmd.exec     = (state_r == S_EXEC);
  assign cmd.pop      = (state_r == S_POP);
  assign cmd.load_out = (state_r == S_OUT) && sts.out_free;

endmodule

// ===== rtl/two_class_priority_queue_server_unit.sv =====
// Each event passes through accept, push/tick, FIFO read and result load in turn;
// the next event is not accepted until its result is loaded, which waits while
// the result register is stalled.
// Reset (rst_n low, synchronous): both FIFOs empty, server idle, queue_limit 64,
// no result pending. FIFO storage is not cleared.
module two_class_priority_queue_server_unit #(
  parameter int FIFO_DEPTH = 64,
  parameter int TAG_BITS   = 16,
  parameter int TICK_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  tcpq_in_if.sink                             in_ch,
  tcpq_out_if.source                          out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [tcpq_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [tcpq_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [tcpq_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import tcpq_pkg::*;

  logic [LIMIT_W-1:0] queue_limit_r;
  logic               cfg_wr;
  logic               reg_hit;
  ctrl_cmd_t          cmd;
  ctrl_sts_t          sts;

  assign reg_hit    = (cfg_paddr[2] == REG_QUEUE_LIMIT);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_hit ? CFG_DATA_W'(queue_limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_limit_r <= QUEUE_LIMIT_RESET;
    end else if (cfg_wr && reg_hit) begin
      queue_limit_r <= cfg_pwdata[LIMIT_W-1:0];
    end
  end

  tcpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcpq_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .TAG_BITS   (TAG_BITS),
    .TICK_BITS  (TICK_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_item     (in_ch.item),
    .queue_limit (queue_limit_r),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_item    (out_ch.item)
  );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpq_pkg::*;

  localparam int FIFO_DEPTH     = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;

  // operation code the block must ignore
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] LIMIT_ADDR = {REG_QUEUE_LIMIT, 2'b00};

  typedef struct {
    logic [PKT_TAG_W-1:0]  tag;
    logic [PKT_TICK_W-1:0] ticks;
  } pkt_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  tcpq_in_if  in_ch ();
  tcpq_out_if out_ch ();

  two_class_priority_queue_server_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted block state
  pkt_t                 data_fifo[$];
  pkt_t                 fb_fifo[$];
  logic                 srv_busy;
  logic [PKT_TICK_W-1:0] srv_ticks_left;
  logic [LIMIT_W-1:0]   limit_reg;

  out_item_t pending_results[$];
  int        n_errors;
  int        stall_cycles;
  int        hold_left;
  bit        quiet;

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  // take the next waiting packet, data class first
  function automatic void start_service(inout out_item_t res);
    pkt_t p;
    if (data_fifo.size() > 0) begin
      p = data_fifo.pop_front();
      res.sent_is_feedback = 1'b0;
    end else if (fb_fifo.size() > 0) begin
      p = fb_fifo.pop_front();
      res.sent_is_feedback = 1'b1;
    end else begin
      srv_busy       = 1'b0;
      srv_ticks_left = '0;
      return;
    end
    res.sent_valid = 1'b1;
    res.sent_tag   = p.tag;
    srv_busy       = 1'b1;
    srv_ticks_left = p.ticks;
  endfunction

  function automatic out_item_t server_step(in_item_t ev);
    out_item_t res;
    pkt_t      p;
    int        lim;
    res = '0;
    lim = (limit_reg == 0) ? 1 : ((limit_reg > FIFO_DEPTH) ? FIFO_DEPTH : int'(limit_reg));
    p.tag   = ev.packet_tag;
    p.ticks = (ev.service_ticks == 0) ? PKT_TICK_W'(1) : ev.service_ticks;
    case (ev.operation)
      OP_DATA, OP_FEEDBACK: begin
        if (ev.operation == OP_DATA) begin
          if (data_fifo.size() >= lim) res.dropped = 1'b1;
          else data_fifo.push_back(p);
        end else begin
          if (fb_fifo.size() >= lim) res.dropped = 1'b1;
          else fb_fifo.push_back(p);
        end
        if (!srv_busy) start_service(res);
      end
      OP_TICK: begin
        if (srv_busy) begin
          if (srv_ticks_left != 0) srv_ticks_left--;
          if (srv_ticks_left == 0) start_service(res);
        end
      end
      default: ;
    endcase
    res.data_count     = COUNT_W'(data_fifo.size());
    res.feedback_count = COUNT_W'(fb_fifo.size());
    return res;
  endfunction

  // result checking and watchdog
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.item;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: 0x%0h", got);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("sent_valid", 32'(want.sent_valid), 32'(got.sent_valid));
        check_field("sent_tag", 32'(want.sent_tag), 32'(got.sent_tag));
        check_field("sent_is_feedback", 32'(want.sent_is_feedback),
                    32'(got.sent_is_feedback));
        check_field("dropped", 32'(want.dropped), 32'(got.dropped));
        check_field("data_count", 32'(want.data_count), 32'(got.data_count));
        check_field("feedback_count", 32'(want.feedback_count), 32'(got.feedback_count));
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = quiet || ($urandom_range(99) >= 24);
    end
  end

  task automatic send_event(input logic [OP_W-1:0] op, input logic [PKT_TAG_W-1:0] tag,
                            input logic [PKT_TICK_W-1:0] ticks);
    in_item_t ev;
    ev.operation     = op;
    ev.packet_tag    = tag;
    ev.service_ticks = ticks;
    while (!quiet && $urandom_range(99) < 24) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.item  = ev;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(server_step(ev));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_random(int arr_pct, bit wide_ticks);
    int                    r;
    logic [OP_W-1:0]       op;
    logic [PKT_TICK_W-1:0] d;
    r = $urandom_range(99);
    if (r < 4) op = OP_UNKNOWN;
    else if (r < 4 + arr_pct) op = ($urandom_range(99) < 60) ? OP_DATA : OP_FEEDBACK;
    else op = OP_TICK;
    r = $urandom_range(99);
    if (wide_ticks) d = PKT_TICK_W'($urandom_range(16'hFFFF));
    else if (r < 10) d = '0;
    else if (r < 85) d = PKT_TICK_W'($urandom_range(1, 3));
    else d = PKT_TICK_W'($urandom_range(4, 12));
    send_event(op, PKT_TAG_W'($urandom_range(16'hFFFF)), d);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = addr;
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic set_limit(logic [LIMIT_W-1:0] value);
    logic [CFG_DATA_W-1:0] rd;
    wait_drained();
    apb_access(1'b1, LIMIT_ADDR, {{(CFG_DATA_W-LIMIT_W){1'b0}}, value}, rd);
    limit_reg = value;
    apb_access(1'b0, LIMIT_ADDR, '0, rd);
    check_field("queue_limit", 32'(limit_reg), 32'(rd[LIMIT_W-1:0]));
  endtask

  task automatic test_reset_value();
    logic [CFG_DATA_W-1:0] rd;
    apb_access(1'b0, LIMIT_ADDR, '0, rd);
    check_field("queue_limit", 32'(QUEUE_LIMIT_RESET), 32'(rd[LIMIT_W-1:0]));
  endtask

  // idle send, ticks to idle, unknown op, and data-over-feedback priority
  task automatic test_basic_service();
    send_event(OP_DATA, 16'hFFFF, 16'd0);
    send_event(OP_TICK, 16'h0000, 16'hFFFF);
    send_event(OP_TICK, 16'h5A5A, 16'd1);
    send_event(OP_FEEDBACK, 16'h0000, 16'd2);
    send_event(OP_UNKNOWN, 16'h1234, 16'd5);
    send_event(OP_DATA, 16'h00AA, 16'd1);
    send_event(OP_FEEDBACK, 16'h00BB, 16'd1);
    send_event(OP_DATA, 16'h00CC, 16'd1);
    repeat (5) send_event(OP_TICK, 16'h0, 16'h0);
  endtask

  task automatic test_limit_one();
    set_limit(7'd1);
    send_event(OP_DATA, 16'h8001, 16'd3);
    send_event(OP_DATA, 16'h8002, 16'd1);
    send_event(OP_DATA, 16'h8003, 16'd1);
    send_event(OP_FEEDBACK, 16'h8004, 16'd1);
    send_event(OP_FEEDBACK, 16'h8005, 16'd1);
  endtask

  // entries above a lowered limit stay queued, new data arrivals drop, feedback fills to the limit
  task automatic test_shrink_limit();
    set_limit(7'd64);
    repeat (6) send_event(OP_DATA, PKT_TAG_W'($urandom_range(16'hFFFF)), 16'd4);
    set_limit(7'd3);
    repeat (2) send_event(OP_DATA, PKT_TAG_W'($urandom_range(16'hFFFF)), 16'd1);
    repeat (4) send_event(OP_FEEDBACK, PKT_TAG_W'($urandom_range(16'hFFFF)), 16'd1);
  endtask

  task automatic test_random(logic [LIMIT_W-1:0] lim, int n, int arr_pct, bit no_idle,
                             bit wide_ticks);
    set_limit(lim);
    quiet = no_idle;
    repeat (n) send_random(arr_pct, wide_ticks);
    quiet = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    set_limit(7'd64);
    quiet     = 1'b1;
    hold_left = HOLD_CYCLES;
    repeat (60) send_random(50, 1'b0);
    quiet = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.item   = '0;
    out_ch.ready = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    n_errors     = 0;
    stall_cycles = 0;
    hold_left    = 0;
    quiet        = 1'b0;
    srv_busy       = 1'b0;
    srv_ticks_left = '0;
    limit_reg      = QUEUE_LIMIT_RESET;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reset_value();
    test_basic_service();
    test_limit_one();
    test_shrink_limit();
    test_random(7'd0, 250, 40, 1'b0, 1'b0);
    test_random(7'($urandom_range(2, 8)), 300, 45, 1'b1, 1'b0);
    test_random(7'd127, 500, 50, 1'b0, 1'b0);
    test_random(7'($urandom_range(9, 63)), 300, 45, 1'b0, 1'b0);
    test_backpressure();
    // long services: the server ends up busy for good, arrivals still fill and drop
    test_random(7'($urandom_range(1, 64)), 150, 55, 1'b0, 1'b1);

    wait_drained();
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
